// ===== rtl/ipmp_pkg.sv =====
package ipmp_pkg;

  // Field and register widths
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned COORD_W  = 28;
  localparam int unsigned STEP_W   = 24;
  localparam int unsigned OFF_W    = 29;
  localparam int unsigned PHASE_W  = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 29;

  // Datapath widths
  localparam int unsigned PROD_W  = IDX_W + STEP_W;        // index times step
  localparam int unsigned WIDE_W  = PROD_W + 2;            // signed sum before clamp
  localparam int unsigned DIFF_W  = COORD_W + 1;           // signed coordinate difference
  localparam int unsigned SQ_W    = 2 * COORD_W;           // one squared component
  localparam int unsigned RAD_W   = SQ_W + 1;              // sum of two squares
  localparam int unsigned ROOT_W  = COORD_W + 1;           // floor root of RAD_W bits
  localparam int unsigned TRIAL_W = RAD_W + 2;

  // Reset value of the grid step
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(4096);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOTE_A_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTE_A_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOTE_B_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOTE_B_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PATH_OFFSET = 3'd7;

  // Pipeline depth: product, clamp, difference, square, sum, root bits, phase
  localparam int unsigned PIPE_LAT = 5 + ROOT_W + 1;

endpackage

// ===== rtl/interferometric_phase_map_pixel_core.sv =====
// Interferometric phase map, one grid cell per item.
//
// Input channel (in_valid / in_ready): one item names a grid cell by
// in_row_index and in_col_index. Result channel (out_valid / out_ready):
// one item carries out_phase, the fractional turn (4096 = 2*pi) of
// dA - dB + path_offset, where dA and dB are floor distances from the cell
// to transmitters A and B. Configuration is a plain write port: cfg_we
// writes cfg_wdata into the register chosen by cfg_index; write it only
// while no item is in flight.
//
// Throughput: one item per cycle while the skid register is empty. Results
// pass through 35 register stages: two multiplier stages, clamp,
// difference and sum-of-squares stages, the 29-stage square-root pipelines
// (one root bit per stage) for dA and dB, and the phase stage.
//
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: all coordinates and the offset zero, grid step 4096.
//
// When the receiver stalls, the last result moves into a one-entry skid
// register and the pipeline advances once more; after that in_ready drops
// and every stage holds until the skid register drains.
module interferometric_phase_map_pixel_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ipmp_pkg::IDX_W-1:0]      in_row_index,
  input  logic [ipmp_pkg::IDX_W-1:0]      in_col_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ipmp_pkg::PHASE_W-1:0]    out_phase,
  input  logic                            cfg_we,
  input  logic [ipmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipmp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ipmp_pkg::*;

  localparam logic signed [WIDE_W-1:0] COORD_HI = WIDE_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] COORD_LO = -WIDE_W'(1 << (COORD_W - 1));

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] ax_r, ay_r, bx_r, by_r, ox_r, oy_r;
  logic        [STEP_W-1:0]  step_r;
  logic signed [OFF_W-1:0]   off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r   <= '0;
      ay_r   <= '0;
      bx_r   <= '0;
      by_r   <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
      step_r <= STEP_RST;
      off_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOTE_A_X:    ax_r   <= cfg_wdata[COORD_W-1:0];
        REG_MOTE_A_Y:    ay_r   <= cfg_wdata[COORD_W-1:0];
        REG_MOTE_B_X:    bx_r   <= cfg_wdata[COORD_W-1:0];
        REG_MOTE_B_Y:    by_r   <= cfg_wdata[COORD_W-1:0];
        REG_ORIGIN_X:    ox_r   <= cfg_wdata[COORD_W-1:0];
        REG_ORIGIN_Y:    oy_r   <= cfg_wdata[COORD_W-1:0];
        REG_GRID_STEP:   step_r <= cfg_wdata[STEP_W-1:0];
        REG_PATH_OFFSET: off_r  <= cfg_wdata[OFF_W-1:0];
        default:         ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: every stage advances together while the skid register is
  // empty. out_ready never reaches in_ready combinationally.
  // ---------------------------------------------------------------------------
  logic advance;
  logic skid_v_r;
  logic [PHASE_W-1:0] skid_phase_r;

  assign advance  = !skid_v_r;
  assign in_ready = advance;

  // Stage 1: scale indexes by the grid step
  logic              s1_v_r;
  logic [PROD_W-1:0] pcol_r, prow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pcol_r <= PROD_W'(in_col_index) * PROD_W'(step_r);
      prow_r <= PROD_W'(in_row_index) * PROD_W'(step_r);
    end
  end

  // Stage 2: offset from the origin and clamp to the coordinate range
  logic                      s2_v_r;
  logic signed [COORD_W-1:0] x_r, y_r;
  logic signed [WIDE_W-1:0]  x_wide, y_wide;
  logic signed [COORD_W-1:0] x_nxt, y_nxt;

  always_comb begin
    x_wide = WIDE_W'(ox_r) + $signed({2'b00, pcol_r});
    y_wide = WIDE_W'(oy_r) - $signed({2'b00, prow_r});
    priority if (x_wide > COORD_HI) x_nxt = COORD_HI[COORD_W-1:0];
    else if (x_wide < COORD_LO)     x_nxt = COORD_LO[COORD_W-1:0];
    else                            x_nxt = x_wide[COORD_W-1:0];
    priority if (y_wide > COORD_HI) y_nxt = COORD_HI[COORD_W-1:0];
    else if (y_wide < COORD_LO)     y_nxt = COORD_LO[COORD_W-1:0];
    else                            y_nxt = y_wide[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (advance) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  // Stage 3: absolute differences to both transmitters
  logic               s3_v_r;
  logic [COORD_W-1:0] uxa_r, uya_r, uxb_r, uyb_r;
  logic signed [DIFF_W-1:0] dxa, dya, dxb, dyb;

  always_comb begin
    dxa = DIFF_W'(x_r) - DIFF_W'(ax_r);
    dya = DIFF_W'(y_r) - DIFF_W'(ay_r);
    dxb = DIFF_W'(x_r) - DIFF_W'(bx_r);
    dyb = DIFF_W'(y_r) - DIFF_W'(by_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (advance) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      uxa_r <= dxa[DIFF_W-1] ? COORD_W'(-dxa) : dxa[COORD_W-1:0];
      uya_r <= dya[DIFF_W-1] ? COORD_W'(-dya) : dya[COORD_W-1:0];
      uxb_r <= dxb[DIFF_W-1] ? COORD_W'(-dxb) : dxb[COORD_W-1:0];
      uyb_r <= dyb[DIFF_W-1] ? COORD_W'(-dyb) : dyb[COORD_W-1:0];
    end
  end

  // Stage 4: square each component
  logic            s4_v_r;
  logic [SQ_W-1:0] sxa_r, sya_r, sxb_r, syb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (advance) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sxa_r <= SQ_W'(uxa_r) * SQ_W'(uxa_r);
      sya_r <= SQ_W'(uya_r) * SQ_W'(uya_r);
      sxb_r <= SQ_W'(uxb_r) * SQ_W'(uxb_r);
      syb_r <= SQ_W'(uyb_r) * SQ_W'(uyb_r);
    end
  end

  // Stage 5: squared distances
  logic             s5_v_r;
  logic [RAD_W-1:0] rad_a_r, rad_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (advance) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rad_a_r <= RAD_W'(sxa_r) + RAD_W'(sya_r);
      rad_b_r <= RAD_W'(sxb_r) + RAD_W'(syb_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Square-root pipelines: stage s decides root bit ROOT_W-1-s. The remainder
  // holds radicand minus root squared; setting bit b adds root*2^(b+1) + 4^b.
  // ---------------------------------------------------------------------------
  logic              sq_v_r   [ROOT_W];
  logic [RAD_W-1:0]  rem_a_r  [ROOT_W];
  logic [RAD_W-1:0]  rem_b_r  [ROOT_W];
  logic [ROOT_W-1:0] root_a_r [ROOT_W];
  logic [ROOT_W-1:0] root_b_r [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_root
    localparam int unsigned BIT = ROOT_W - 1 - s;

    logic              v_in;
    logic [RAD_W-1:0]  rem_a_in, rem_b_in;
    logic [ROOT_W-1:0] root_a_in, root_b_in;
    logic [TRIAL_W-1:0] trial_a, trial_b;
    logic [RAD_W-1:0]  rem_a_nxt, rem_b_nxt;
    logic [ROOT_W-1:0] root_a_nxt, root_b_nxt;

    if (s == 0) begin : g_first
      assign v_in      = s5_v_r;
      assign rem_a_in  = rad_a_r;
      assign rem_b_in  = rad_b_r;
      assign root_a_in = '0;
      assign root_b_in = '0;
    end else begin : g_next
      assign v_in      = sq_v_r[s-1];
      assign rem_a_in  = rem_a_r[s-1];
      assign rem_b_in  = rem_b_r[s-1];
      assign root_a_in = root_a_r[s-1];
      assign root_b_in = root_b_r[s-1];
    end

    always_comb begin
      trial_a = (TRIAL_W'(root_a_in) << (BIT + 1)) + (TRIAL_W'(1) << (2 * BIT));
      trial_b = (TRIAL_W'(root_b_in) << (BIT + 1)) + (TRIAL_W'(1) << (2 * BIT));
      if (TRIAL_W'(rem_a_in) >= trial_a) begin
        rem_a_nxt  = rem_a_in - trial_a[RAD_W-1:0];
        root_a_nxt = root_a_in | (ROOT_W'(1) << BIT);
      end else begin
        rem_a_nxt  = rem_a_in;
        root_a_nxt = root_a_in;
      end
      if (TRIAL_W'(rem_b_in) >= trial_b) begin
        rem_b_nxt  = rem_b_in - trial_b[RAD_W-1:0];
        root_b_nxt = root_b_in | (ROOT_W'(1) << BIT);
      end else begin
        rem_b_nxt  = rem_b_in;
        root_b_nxt = root_b_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[s] <= 1'b0;
      end else if (advance) begin
        sq_v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem_a_r[s]  <= rem_a_nxt;
        rem_b_r[s]  <= rem_b_nxt;
        root_a_r[s] <= root_a_nxt;
        root_b_r[s] <= root_b_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Phase stage: only the low 12 bits of dA - dB + offset survive the modulo.
  // ---------------------------------------------------------------------------
  logic               ph_v_r;
  logic [PHASE_W-1:0] ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_v_r <= 1'b0;
    end else if (advance) begin
      ph_v_r <= sq_v_r[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ph_r <= root_a_r[ROOT_W-1][PHASE_W-1:0] - root_b_r[ROOT_W-1][PHASE_W-1:0]
            + off_r[PHASE_W-1:0];
    end
  end

  // Skid register: catch the result that the pipeline pushes out while the
  // receiver stalls; drain it first, since it is the older item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (ph_v_r && !out_ready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_phase_r <= ph_r;
    end
  end

  assign out_valid = skid_v_r || ph_v_r;
  assign out_phase = skid_v_r ? skid_phase_r : ph_r;

endmodule

// ===== rtl/ipmp_checker.sv =====
module ipmp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ipmp_pkg::PHASE_W-1:0] out_phase
);
  import ipmp_pkg::*;

  // The pipeline is empty after reset, so no result follows at once.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid ##1 !out_valid)
    else $error("result appeared too soon after reset");

  // Input backpressure only ever comes from a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phase))
    else $error("stalled result changed or dropped");

  // Once the receiver takes a result, the input side reopens next cycle.
  a_ready_recover: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && out_ready |=> in_ready)
    else $error("input did not reopen after drain");

endmodule

bind interferometric_phase_map_pixel_core ipmp_checker u_ipmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_phase (out_phase)
);
